// ===== rtl/pts_pkg.sv =====
// ----------------------------------------------------------------------------
// pts_pkg: shared types and constants of the priority task scheduler.
// Holds the operation codes, task state codes and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none
package pts_pkg;

  // Service operation codes.
  localparam logic [3:0] FN_SCHEDULE = 4'd0;
  localparam logic [3:0] FN_TICK     = 4'd1;
  localparam logic [3:0] FN_GET_RES  = 4'd2;
  localparam logic [3:0] FN_REL_RES  = 4'd3;
  localparam logic [3:0] FN_SET_EV   = 4'd4;
  localparam logic [3:0] FN_CLR_EV   = 4'd5;
  localparam logic [3:0] FN_GET_EV   = 4'd6;
  localparam logic [3:0] FN_WAIT_EV  = 4'd7;
  localparam logic [3:0] FN_SET_TMR  = 4'd8;

  // Task states.
  localparam logic [1:0] ST_INACTIVE = 2'd0;
  localparam logic [1:0] ST_READY    = 2'd1;
  localparam logic [1:0] ST_RUNNING  = 2'd2;
  localparam logic [1:0] ST_WAITING  = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] REG_TASK_COUNT = 3'd0;
  localparam logic [2:0] REG_PRIO       = 3'd1;
  localparam logic [2:0] REG_RES        = 3'd2;
  localparam logic [2:0] REG_TMR_OWNER  = 3'd3;
  localparam logic [2:0] REG_TMR_EVENT  = 3'd4;
  localparam logic [2:0] REG_INIT_READY = 3'd5;

  // Token handed from cell to cell during the scheduling scan.
  typedef struct packed {
    logic       found;
    logic [7:0] best;
    logic [3:0] idx;
  } pts_scan_t;

endpackage
`default_nettype wire

// ===== rtl/priority_task_scheduler_with_events.sv =====
// ----------------------------------------------------------------------------
// priority_task_scheduler_with_events: fixed-priority preemptive task manager.
// Channel | Dir | Contents
// in_     | in  | func, task_index, mask, timer_index, timer_load
// out_    | out | running_task, switched, event_bits, schedule_request,
//         |     | now_waiting
// cfg_    | in  | register writes, index and data
// A schedule goes from input to result transaction through the scan, which
// walks a chain of MAX_TASKS cells, one register stage per task; other
// operations pass the scan state without waiting on the chain. One item is
// worked on at a time; the result sits in an output register and a new item
// is taken from the cycle after it has been handed over, so a stalled output
// holds off the input. Reset is synchronous.
// ----------------------------------------------------------------------------
`default_nettype none
module priority_task_scheduler_with_events #(
  parameter int MAX_TASKS  = 8,
  parameter int MAX_TIMERS = 8
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_tvalid,
  output logic       in_tready,
  // [3:0] func, [6:4] task_index, [14:7] mask, [17:15] timer_index,
  // [25:18] timer_load
  input  wire [31:0] in_tdata,
  output logic       out_tvalid,
  input  wire        out_tready,
  // [2:0] running_task, [3] switched, [11:4] event_bits,
  // [12] schedule_request, [13] now_waiting
  output logic [15:0] out_tdata,
  input  wire        cfg_we,
  input  wire [2:0]  cfg_index,
  input  wire [63:0] cfg_data
);
  import pts_pkg::*;

  localparam int TW = $clog2(MAX_TASKS);
  localparam int MW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
  localparam int SCW = $clog2(MAX_TASKS + 2);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_OUT  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic [3:0]  task_count_r;
  logic [63:0] prio_r, res_r, tev_r;
  logic [23:0] towner_r;
  logic [7:0]  init_ready_r;

  // Task and timer state.
  logic [1:0]  tstate_r [MAX_TASKS];
  logic [7:0]  tevents_r [MAX_TASKS];
  logic [7:0]  twait_r [MAX_TASKS];
  logic [7:0]  tcount_r [MAX_TIMERS];
  logic [7:0]  occ_r;
  logic [TW-1:0] cur_r;

  // Latched input item.
  logic [3:0]  func_r;
  logic [2:0]  tidx_r;
  logic [7:0]  mask_r;
  logic [2:0]  tmr_r;
  logic [7:0]  load_r;
  logic [SCW-1:0] cnt_r;

  // Output register.
  logic [15:0] out_r;

  function automatic logic [7:0] prio_of(input logic [63:0] p, input int t);
    if (t >= 8) return 8'd0;
    return p[8*t +: 8];
  endfunction

  // Scan chain of cells, one per task.
  pts_scan_t tok [MAX_TASKS+1];
  assign tok[0] = '{found: 1'b0, best: 8'd0, idx: 4'd0};
  logic [4:0] n_eff;
  assign n_eff = ({1'b0, task_count_r} > 5'(MAX_TASKS)) ? 5'(MAX_TASKS)
                                                        : {1'b0, task_count_r};

  for (genvar g = 0; g < MAX_TASKS; g++) begin : g_cell
    logic elig;
    assign elig = (5'(g) < n_eff) && (tstate_r[g] == ST_READY) &&
                  ((prio_of(res_r, g) & occ_r) == 8'd0);
    pts_scan_cell u_cell (
      .clk     (clk),
      .my_idx  (4'(g)),
      .eligible(elig),
      .prio    (prio_of(prio_r, g)),
      .tok_in  (tok[g]),
      .tok_out (tok[g+1])
    );
  end

  // Input fields.
  logic [3:0] in_func;
  assign in_func = in_tdata[3:0];

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = out_r;

  // Combined result computation for the latched item.
  logic [1:0]  ts_n [MAX_TASKS];
  logic [7:0]  te_n [MAX_TASKS];
  logic [7:0]  tw_n [MAX_TASKS];
  logic [7:0]  tc_n [MAX_TIMERS];
  logic [7:0]  occ_n;
  logic [TW-1:0] cur_n;
  logic        sw_n, req_n, wt_n;
  logic        do_post;
  logic [3:0]  post_t;
  logic [7:0]  post_m;
  logic [TW-1:0] nxt;
  logic [7:0]  cnt_dec;

  always_comb begin
    for (int i = 0; i < MAX_TASKS; i++) begin
      ts_n[i] = tstate_r[i];
      te_n[i] = tevents_r[i];
      tw_n[i] = twait_r[i];
    end
    for (int i = 0; i < MAX_TIMERS; i++) tc_n[i] = tcount_r[i];
    occ_n   = occ_r;
    cur_n   = cur_r;
    sw_n    = 1'b0;
    req_n   = 1'b0;
    wt_n    = 1'b0;
    do_post = 1'b0;
    post_t  = {1'b0, tidx_r};
    post_m  = mask_r;
    nxt     = TW'(tok[MAX_TASKS].idx);
    cnt_dec = 8'd0;
    case (func_r)
      FN_SCHEDULE: begin
        if (tstate_r[cur_r] == ST_READY || tstate_r[cur_r] == ST_WAITING) begin
          ts_n[nxt] = ST_RUNNING;
          cur_n = nxt;
        end else if (tstate_r[cur_r] == ST_RUNNING) begin
          if (prio_of(prio_r, int'(nxt)) > prio_of(prio_r, int'(cur_r))) begin
            ts_n[cur_r] = ST_READY;
            ts_n[nxt] = ST_RUNNING;
            cur_n = nxt;
          end
        end
        sw_n = (cur_n != cur_r);
      end
      FN_TICK: begin
        if (32'(tmr_r) < MAX_TIMERS) begin
          if (tcount_r[MW'(tmr_r)] != 8'd0) begin
            cnt_dec = tcount_r[MW'(tmr_r)] - 8'd1;
            tc_n[MW'(tmr_r)] = cnt_dec;
            if (cnt_dec == 8'd0) begin
              do_post = 1'b1;
              post_t  = {1'b0, towner_r[3*tmr_r +: 3]};
              post_m  = tev_r[8*tmr_r +: 8];
            end
          end
        end
      end
      FN_GET_RES: occ_n = occ_r | mask_r;
      FN_REL_RES: begin
        occ_n = occ_r & ~mask_r;
        req_n = 1'b1;
      end
      FN_SET_EV: do_post = 1'b1;
      FN_CLR_EV: te_n[cur_r] = tevents_r[cur_r] & ~mask_r;
      FN_GET_EV: ;
      FN_WAIT_EV: begin
        tw_n[cur_r] = twait_r[cur_r] | mask_r;
        if ((tevents_r[cur_r] & mask_r) == 8'd0) begin
          ts_n[cur_r] = ST_WAITING;
          req_n = 1'b1;
          wt_n  = 1'b1;
        end
      end
      FN_SET_TMR: if (32'(tmr_r) < MAX_TIMERS) tc_n[MW'(tmr_r)] = load_r;
      default: ;
    endcase
    // Event posting shared by set event and timer expiry.
    if (do_post && (32'(post_t) < MAX_TASKS)) begin
      te_n[TW'(post_t)] = tevents_r[TW'(post_t)] | post_m;
      if ((twait_r[TW'(post_t)] & te_n[TW'(post_t)]) != 8'd0) begin
        ts_n[TW'(post_t)] = ST_READY;
        req_n = (prio_of(prio_r, int'(post_t)) > prio_of(prio_r, int'(cur_r)));
      end
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_tvalid) state_nxt = S_SCAN;
      S_SCAN: if (func_r != FN_SCHEDULE || cnt_r == SCW'(MAX_TASKS)) state_nxt = S_OUT;
      S_OUT:  if (out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      task_count_r <= 4'd8;
      prio_r <= '0; res_r <= '0; tev_r <= '0; towner_r <= '0;
      init_ready_r <= 8'd1;
      for (int i = 0; i < MAX_TASKS; i++) begin
        tstate_r[i]  <= (i == 0) ? ST_READY : ST_INACTIVE;
        tevents_r[i] <= '0;
        twait_r[i]   <= '0;
      end
      for (int i = 0; i < MAX_TIMERS; i++) tcount_r[i] <= '0;
      occ_r <= '0;
      cur_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_IDLE && in_tvalid) begin
        func_r <= in_func;
        tidx_r <= in_tdata[6:4];
        mask_r <= in_tdata[14:7];
        tmr_r  <= in_tdata[17:15];
        load_r <= in_tdata[25:18];
        cnt_r  <= '0;
      end
      if (state_r == S_SCAN) begin
        cnt_r <= cnt_r + SCW'(1);
        if (state_nxt == S_OUT) begin
          for (int i = 0; i < MAX_TASKS; i++) begin
            tstate_r[i]  <= ts_n[i];
            tevents_r[i] <= te_n[i];
            twait_r[i]   <= tw_n[i];
          end
          for (int i = 0; i < MAX_TIMERS; i++) tcount_r[i] <= tc_n[i];
          occ_r <= occ_n;
          cur_r <= cur_n;
          out_r <= {2'b00, wt_n, req_n, te_n[cur_n], sw_n, 3'(cur_n)};
        end
      end
      // Configuration writes, to be taken only while idle; the user must keep to this, the block does not enforce it.
      if (cfg_we) begin
        case (cfg_index)
          REG_TASK_COUNT: task_count_r <= cfg_data[3:0];
          REG_PRIO:       prio_r <= cfg_data;
          REG_RES:        res_r <= cfg_data;
          REG_TMR_OWNER:  towner_r <= cfg_data[23:0];
          REG_TMR_EVENT:  tev_r <= cfg_data;
          REG_INIT_READY: begin
            init_ready_r <= cfg_data[7:0];
            for (int i = 0; i < MAX_TASKS; i++)
              tstate_r[i] <= (i < 8 && cfg_data[i]) ? ST_READY : ST_INACTIVE;
          end
          default: ;
        endcase
      end
    end
  end

  logic unused_ok;
  assign unused_ok = ^{init_ready_r, in_tdata[31:26], tok[MAX_TASKS].found,
                       tok[MAX_TASKS].best};
endmodule
`default_nettype wire

// ===== rtl/pts_scan_cell.sv =====
// ----------------------------------------------------------------------------
// pts_scan_cell: one stage of the scheduling scan chain.
// Compares its task against the best candidate so far and passes it on.
// ----------------------------------------------------------------------------
`default_nettype none
module pts_scan_cell (
  input  wire                 clk,
  input  wire  [3:0]          my_idx,
  input  wire                 eligible,
  input  wire  [7:0]          prio,
  input  pts_pkg::pts_scan_t  tok_in,
  output pts_pkg::pts_scan_t  tok_out
);
  import pts_pkg::*;

  pts_scan_t tok_r, tok_nxt;

  // Strictly greater priority takes over the token.
  always_comb begin
    tok_nxt = tok_in;
    if (eligible && (prio > tok_in.best)) begin
      tok_nxt.best  = prio;
      tok_nxt.idx   = my_idx;
      tok_nxt.found = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    tok_r <= tok_nxt;
  end

  assign tok_out = tok_r;
endmodule
`default_nettype wire

// ===== rtl/pts_checker.sv =====
// ----------------------------------------------------------------------------
// pts_checker: port-level checks of the task scheduler.
// Watches handshakes and result fields over time.
// ----------------------------------------------------------------------------
`default_nettype none
module pts_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_tvalid,
  input wire        in_tready,
  input wire        out_tvalid,
  input wire        out_tready,
  input wire [15:0] out_tdata
);
  // A held result stays stable.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // No new input while a result is pending.
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input taken with result pending");

  // An accepted item cannot produce a result in the next cycle.
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !out_tvalid)
    else $error("result too early");

  // Waiting always comes with a schedule request.
  a_wait: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[13] |-> out_tdata[12])
    else $error("waiting without schedule request");
endmodule

bind priority_task_scheduler_with_events pts_checker u_pts_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);
`default_nettype wire

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking testbench of the priority task scheduler.
// A queue of service calls feeds a clocked driver. A clocked monitor checks
// every result transaction against a scheduler model kept in the bench. Both
// stream sides idle at random, and the registers are rewritten between phases.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pts_pkg::*;

  typedef struct packed {
    logic [7:0] load;
    logic [2:0] tmr;
    logic [7:0] mask;
    logic [2:0] tsk;
    logic [3:0] func;
  } call_t;

  typedef struct packed {
    logic       waiting;
    logic       req;
    logic [7:0] events;
    logic       sw;
    logic [2:0] running;
  } status_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [31:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  priority_task_scheduler_with_events dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Scheduler model: configuration and state.
  logic [3:0]  m_count;
  logic [63:0] m_prio, m_res, m_tev;
  logic [23:0] m_owner;
  logic [7:0]  m_ready;
  logic [1:0]  m_state [8];
  logic [7:0]  m_ev [8];
  logic [7:0]  m_wait [8];
  logic [7:0]  m_timer [8];
  logic [7:0]  m_occ;
  logic [2:0]  m_cur;

  call_t   call_q [$];
  status_t status_q [$];
  int errors = 0;
  int n_results = 0;
  int n_switch = 0;
  int n_wait = 0;
  int n_req = 0;
  int cycles = 0;

  function automatic logic [7:0] prio_of(input logic [2:0] t);
    return m_prio[8*t +: 8];
  endfunction

  function automatic void load_ready();
    for (int i = 0; i < 8; i++) m_state[i] = m_ready[i] ? ST_READY : ST_INACTIVE;
  endfunction

  function automatic void model_reset();
    m_count = 4'd8; m_prio = '0; m_res = '0; m_owner = '0; m_tev = '0;
    m_ready = 8'd1;
    load_ready();
    for (int i = 0; i < 8; i++) begin
      m_ev[i] = '0; m_wait[i] = '0; m_timer[i] = '0;
    end
    m_occ = '0;
    m_cur = '0;
  endfunction

  function automatic logic post_event(input logic [2:0] t, input logic [7:0] m);
    m_ev[t] = m_ev[t] | m;
    if ((m_wait[t] & m_ev[t]) != 0) begin
      m_state[t] = ST_READY;
      return prio_of(t) > prio_of(m_cur);
    end
    return 1'b0;
  endfunction

  function automatic logic run_schedule();
    int n;
    logic [2:0] pick, prev;
    logic [7:0] best;
    n = (m_count > 8) ? 8 : m_count;
    pick = '0;
    best = '0;
    prev = m_cur;
    for (int i = 0; i < n; i++)
      if (m_state[i] == ST_READY && (m_res[8*i +: 8] & m_occ) == 0 &&
          prio_of(3'(i)) > best) begin
        best = prio_of(3'(i));
        pick = 3'(i);
      end
    if (m_state[prev] == ST_READY || m_state[prev] == ST_WAITING) begin
      m_state[pick] = ST_RUNNING;
      m_cur = pick;
    end else if (m_state[prev] == ST_RUNNING && prio_of(pick) > prio_of(prev)) begin
      m_state[prev] = ST_READY;
      m_state[pick] = ST_RUNNING;
      m_cur = pick;
    end
    return m_cur != prev;
  endfunction

  function automatic status_t service(input call_t c);
    status_t s;
    logic [2:0] cur;
    s = '0;
    cur = m_cur;
    case (c.func)
      FN_SCHEDULE: s.sw = run_schedule();
      FN_TICK: if (m_timer[c.tmr] != 0) begin
        m_timer[c.tmr]--;
        if (m_timer[c.tmr] == 0)
          s.req = post_event(m_owner[3*c.tmr +: 3], m_tev[8*c.tmr +: 8]);
      end
      FN_GET_RES: m_occ |= c.mask;
      FN_REL_RES: begin
        m_occ &= ~c.mask;
        s.req = 1'b1;
      end
      FN_SET_EV: s.req = post_event(c.tsk, c.mask);
      FN_CLR_EV: m_ev[cur] &= ~c.mask;
      FN_WAIT_EV: begin
        m_wait[cur] |= c.mask;
        if ((m_ev[cur] & c.mask) == 0) begin
          m_state[cur] = ST_WAITING;
          s.req = 1'b1;
          s.waiting = 1'b1;
        end
      end
      FN_SET_TMR: m_timer[c.tmr] = c.load;
      default: ;
    endcase
    s.running = m_cur;
    s.events = m_ev[m_cur];
    return s;
  endfunction

  // Driver: takes calls from the queue, with a random gap before each.
  int gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        status_q.push_back(service(call_t'(in_tdata[25:0])));
        void'(call_q.pop_front());
        gap = $urandom_range(0, 5);
      end
      if (in_tvalid && !in_tready) begin
      end else if (gap > 0) begin
        in_tvalid <= 1'b0;
        gap--;
      end else if ((!in_tvalid || in_tready) && call_q.size() > ((in_tvalid && !in_tready) ? 1 : 0)) begin
        in_tvalid <= 1'b1;
        in_tdata <= {6'd0, call_q[0]};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: checks each result transaction and draws a random stall.
  int stall = 0;
  always @(posedge clk) begin
    cycles++;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        status_t got, want;
        got = status_t'(out_tdata[13:0]);
        n_results++;
        if (status_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual %h", $time, got);
        end else begin
          want = status_q.pop_front();
          if (got.sw) n_switch++;
          if (got.waiting) n_wait++;
          if (got.req) n_req++;
          if (got.running !== want.running)
            $display("%0t: running_task expected %0d, actual %0d", $time, want.running, got.running);
          if (got.sw !== want.sw)
            $display("%0t: switched expected %0d, actual %0d", $time, want.sw, got.sw);
          if (got.events !== want.events)
            $display("%0t: event_bits expected %h, actual %h", $time, want.events, got.events);
          if (got.req !== want.req)
            $display("%0t: schedule_request expected %0d, actual %0d", $time, want.req, got.req);
          if (got.waiting !== want.waiting)
            $display("%0t: now_waiting expected %0d, actual %0d", $time, want.waiting, got.waiting);
          if (got !== want) errors++;
        end
        stall = $urandom_range(0, 5);
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        stall--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Register write, only issued while the block is idle.
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_TASK_COUNT: m_count = val[3:0];
      REG_PRIO:       m_prio = val;
      REG_RES:        m_res = val;
      REG_TMR_OWNER:  m_owner = val[23:0];
      REG_TMR_EVENT:  m_tev = val;
      REG_INIT_READY: begin
        m_ready = val[7:0];
        load_ready();
      end
      default: ;
    endcase
  endtask

  task automatic drain();
    while (call_q.size() != 0 || status_q.size() != 0 || in_tvalid) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic void add(input logic [3:0] f, input logic [2:0] t, input logic [7:0] m,
                              input logic [2:0] r, input logic [7:0] l);
    call_t c;
    c.func = f; c.tsk = t; c.mask = m; c.tmr = r; c.load = l;
    call_q.push_back(c);
  endfunction

  // Random service call, weighted toward schedules, timer ticks and set event.
  function automatic void add_random();
    int k;
    logic [2:0] t, r;
    logic [7:0] m, l;
    k = $urandom_range(0, 99);
    t = 3'($urandom);
    r = 3'($urandom);
    m = 8'($urandom);
    l = 8'($urandom);
    if (k < 20) add(FN_SCHEDULE, t, m, r, l);
    else if (k < 38) add(FN_TICK, t, m, r, l);
    else if (k < 44) add(FN_GET_RES, t, 8'd1 << $urandom_range(0, 7), r, l);
    else if (k < 50) add(FN_REL_RES, t, m, r, l);
    else if (k < 64) add(FN_SET_EV, t, m, r, l);
    else if (k < 70) add(FN_CLR_EV, t, m, r, l);
    else if (k < 74) add(FN_GET_EV, t, m, r, l);
    else if (k < 84) add(FN_WAIT_EV, t, m, r, l);
    else if (k < 96) add(FN_SET_TMR, t, m, r, 8'($urandom_range(0, 4)));
    else add(4'($urandom_range(9, 15)), t, m, r, l);
  endfunction

  task automatic configure(input logic [3:0] count, input logic [63:0] prio,
                           input logic [63:0] res, input logic [7:0] ready);
    write_reg(REG_TASK_COUNT, 64'(count));
    write_reg(REG_PRIO, prio);
    write_reg(REG_RES, res);
    write_reg(REG_TMR_OWNER, {$urandom, $urandom});
    write_reg(REG_TMR_EVENT, {$urandom, $urandom});
    write_reg(REG_INIT_READY, 64'(ready));
  endtask

  initial begin
    model_reset();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed calls on reset settings, then on extreme settings.
    add(FN_SCHEDULE, 0, 0, 0, 0);
    add(FN_GET_EV, 0, 0, 0, 0);
    add(FN_WAIT_EV, 0, 8'h01, 0, 0);
    add(FN_SCHEDULE, 0, 0, 0, 0);
    add(FN_SET_EV, 3'd7, 8'hFF, 0, 0);
    add(FN_SET_EV, 3'd0, 8'h01, 0, 0);
    add(4'd15, 3'd7, 8'hFF, 3'd7, 8'hFF);
    drain();
    configure(4'd15, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF);
    add(FN_SCHEDULE, 0, 0, 0, 0);
    add(FN_GET_RES, 0, 8'hFF, 0, 0);
    add(FN_SCHEDULE, 0, 0, 0, 0);
    add(FN_REL_RES, 0, 8'hFF, 0, 0);
    add(FN_SET_TMR, 0, 0, 3'd7, 8'd1);
    add(FN_TICK, 0, 0, 3'd7, 0);
    add(FN_TICK, 0, 0, 3'd7, 0);
    add(FN_SET_TMR, 0, 0, 3'd0, 8'hFF);
    add(FN_TICK, 0, 0, 3'd0, 0);
    add(FN_CLR_EV, 0, 8'hFF, 0, 0);
    add(FN_WAIT_EV, 0, 8'h80, 0, 0);
    add(FN_SCHEDULE, 0, 0, 0, 0);
    drain();
    configure(4'd0, 64'h0102_0304_0506_0708, '0, 8'h00);
    add(FN_SCHEDULE, 0, 0, 0, 0);
    add(FN_SET_EV, 3'd5, 8'h10, 0, 0);
    add(FN_SCHEDULE, 0, 0, 0, 0);
    drain();

    // Random phases with random settings, task count 1 and 8 among them.
    for (int p = 0; p < 7; p++) begin
      configure((p == 0) ? 4'd1 : (p == 1) ? 4'd8 : 4'($urandom_range(1, 9)),
                {$urandom, $urandom}, {$urandom, $urandom} & {8{8'h11}},
                8'($urandom));
      for (int i = 0; i < 200; i++) begin
        add_random();
        // Hold off once, midway through the phase, until everything has come back.
        if (i == 100) begin
          while (call_q.size() != 0 || status_q.size() != 0) @(posedge clk);
        end
      end
      drain();
    end

    $display("Checked %0d results: %0d switches, %0d waits, %0d schedule requests.",
             n_results, n_switch, n_wait, n_req);
    $display("Covered all service calls over ten register settings.");
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Timeout guard.
  always @(posedge clk) begin
    if (cycles > 200000) begin
      $display("Timeout after %0d cycles.", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end
endmodule
